// ===== hw/rtl/ostw_pkg.sv =====
// ----------------------------------------------------------------------------
// ostw_pkg
// Shared widths, table geometry and register codes of the waveshaper.
// ----------------------------------------------------------------------------
package ostw_pkg;

  // table geometry
  localparam int TABLE_BITS  = 9;
  localparam int FRAC_W      = 7;
  localparam int TABLE_LEN   = 1 << TABLE_BITS;
  localparam int TABLE_DEPTH = TABLE_LEN + 1;
  localparam int ADDR_W      = TABLE_BITS + 1;

  // field widths
  localparam int ENTRY_ADDR_W = 10;
  localparam int ENTRY_W      = 18;
  localparam int SAMPLE_IN_W  = 20;
  localparam int SAMPLE_OUT_W = 24;
  localparam int SLOPE_W      = 19;
  localparam int OFFSET_W     = 18;

  // configuration port
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 19;

  // fixed point
  localparam int Q_FRAC  = 16;
  localparam int ONE_Q16 = 1 << Q_FRAC;
  localparam int OUT_MAX = (1 << (SAMPLE_OUT_W - 1)) - 1;
  localparam int OUT_MIN = -(1 << (SAMPLE_OUT_W - 1));

  // register reset values and tail slope limit
  localparam int SLOPE_RESET  = 65536;
  localparam int OFFSET_RESET = 0;
  localparam int SLOPE_LIMIT  = 131072;

  localparam logic OP_LOAD   = 1'b0;
  localparam logic OP_SAMPLE = 1'b1;

  // register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_TAIL_SLOPE  = 1'b0,
    CFG_TAIL_OFFSET = 1'b1
  } cfg_idx_t;

endpackage

// ===== hw/rtl/ostw_if.sv =====
// ----------------------------------------------------------------------------
// ostw_if
// Valid/ready stream interfaces for the waveshaper input and result channels.
// ----------------------------------------------------------------------------

// input channel: load and sample transactions
interface ostw_in_if;
  logic                                   valid;
  logic                                   ready;
  logic                                   op;
  logic [ostw_pkg::ENTRY_ADDR_W-1:0]      entry_addr;
  logic signed [ostw_pkg::ENTRY_W-1:0]    entry_value;
  logic signed [ostw_pkg::SAMPLE_IN_W-1:0] sample_in;
  logic                                   block_end;

  modport source (
    output valid, op, entry_addr, entry_value, sample_in, block_end,
    input  ready
  );
  modport sink (
    input  valid, op, entry_addr, entry_value, sample_in, block_end,
    output ready
  );
endinterface

// result channel: shaped samples
interface ostw_out_if;
  logic                                    valid;
  logic                                    ready;
  logic signed [ostw_pkg::SAMPLE_OUT_W-1:0] sample_out;
  logic                                    block_end_out;

  modport source (
    output valid, sample_out, block_end_out,
    input  ready
  );
  modport sink (
    input  valid, sample_out, block_end_out,
    output ready
  );
endinterface

// ===== hw/rtl/odd_symmetric_table_waveshaper.sv =====
// ----------------------------------------------------------------------------
// odd_symmetric_table_waveshaper
// Table lookup waveshaper with linear interpolation, linear tail beyond
// magnitude one, odd symmetry and saturation to Q7.16.
// ----------------------------------------------------------------------------
// Pipeline: a sample transaction passes the table read, operand select,
// multiply, add/saturate and sign registers before the result channel.
// Throughput: one transaction per cycle; the pipeline moves as a whole and
// stops only while a result waits on the output register.
// Reset: synchronous active-low rst_n clears the valid bits and loads the tail
// registers; the curve table is not cleared and must be loaded before use.
// ----------------------------------------------------------------------------
module odd_symmetric_table_waveshaper (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [ostw_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [ostw_pkg::CFG_DATA_W-1:0] cfg_data,
  ostw_in_if.sink                         in_if,
  ostw_out_if.source                      out_if
);
  import ostw_pkg::*;

  // magnitude scaling
  localparam int MAG_W    = SAMPLE_IN_W;
  localparam int SH       = TABLE_BITS + FRAC_W - Q_FRAC;
  localparam int SH_L     = (SH > 0) ? SH : 0;
  localparam int SH_R     = (SH < 0) ? -SH : 0;
  localparam int SCALED_W = MAG_W + SH_L;
  localparam int DM_W     = MAG_W - 1;
  localparam int OP_W     = SLOPE_W;
  localparam int MB_W     = DM_W + 1;
  localparam int PROD_W   = OP_W + MB_W;
  localparam int SUM_W    = 26;

  localparam logic signed [SLOPE_W-1:0]      SLOPE_HI = SLOPE_W'(SLOPE_LIMIT);
  localparam logic signed [SLOPE_W-1:0]      SLOPE_LO = SLOPE_W'(-SLOPE_LIMIT);
  localparam logic signed [SUM_W-1:0]        SUM_MAX  = SUM_W'(OUT_MAX);
  localparam logic signed [SUM_W-1:0]        SUM_MIN  = SUM_W'(OUT_MIN);
  localparam logic signed [SAMPLE_OUT_W-1:0] Y_MAX    = SAMPLE_OUT_W'(OUT_MAX);
  localparam logic signed [SAMPLE_OUT_W-1:0] Y_MIN    = SAMPLE_OUT_W'(OUT_MIN);

  // configuration registers
  logic signed [SLOPE_W-1:0]  tail_slope_r;
  logic signed [OFFSET_W-1:0] tail_offset_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tail_slope_r  <= SLOPE_W'(SLOPE_RESET);
      tail_offset_r <= OFFSET_W'(OFFSET_RESET);
    end else if (cfg_we) begin
      case (cfg_idx_t'(cfg_index))
        CFG_TAIL_SLOPE:  tail_slope_r  <= SLOPE_W'(cfg_data);
        CFG_TAIL_OFFSET: tail_offset_r <= OFFSET_W'(cfg_data);
        default: ;
      endcase
    end
  end

  // pipeline advance and input handshake
  logic out_valid_r;
  logic adv;
  logic in_acc;

  assign adv         = !out_valid_r || out_if.ready;
  assign in_if.ready = adv;
  assign in_acc      = in_if.valid && adv;

  // stage 0: magnitude, index and fraction
  logic               s0_neg;
  logic [MAG_W-1:0]   s0_mag;
  logic [SCALED_W-1:0] s0_scaled;
  logic               s0_tail;
  logic [ADDR_W-1:0]  s0_addr0;
  logic [ADDR_W-1:0]  s0_addr1;

  always_comb begin
    s0_neg    = in_if.sample_in[SAMPLE_IN_W-1];
    s0_mag    = s0_neg ? MAG_W'(-in_if.sample_in) : MAG_W'(in_if.sample_in);
    s0_scaled = (SCALED_W'(s0_mag) << SH_L) >> SH_R;
    s0_tail   = |s0_scaled[SCALED_W-1:TABLE_BITS+FRAC_W];
    s0_addr0  = {1'b0, s0_scaled[FRAC_W +: TABLE_BITS]};
    s0_addr1  = s0_addr0 + ADDR_W'(1);
  end

  // table write for load transactions
  logic              tbl_we;
  logic [ADDR_W-1:0] tbl_waddr;

  assign tbl_we = in_acc && (in_if.op == OP_LOAD) &&
                  (32'(in_if.entry_addr) <= TABLE_LEN);
  assign tbl_waddr = ADDR_W'(in_if.entry_addr);

  // two copies of the curve table, one per interpolation point
  logic [ENTRY_W-1:0] e0_q;
  logic [ENTRY_W-1:0] e1_q;

  ostw_ram #(.WIDTH(ENTRY_W), .DEPTH(TABLE_DEPTH)) u_tbl_lo (
    .clk   (clk),
    .we    (tbl_we),
    .waddr (tbl_waddr),
    .wdata (in_if.entry_value),
    .re    (adv),
    .raddr (s0_addr0),
    .rdata (e0_q)
  );

  ostw_ram #(.WIDTH(ENTRY_W), .DEPTH(TABLE_DEPTH)) u_tbl_hi (
    .clk   (clk),
    .we    (tbl_we),
    .waddr (tbl_waddr),
    .wdata (in_if.entry_value),
    .re    (adv),
    .raddr (s0_addr1),
    .rdata (e1_q)
  );

  // stage 1 registers, alongside the table read
  logic                 s1_valid_r;
  logic                 s1_neg_r;
  logic                 s1_tail_r;
  logic                 s1_be_r;
  logic [FRAC_W-1:0]    s1_frac_r;
  logic [DM_W-1:0]      s1_dm_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (adv) begin
      s1_valid_r <= in_if.valid && (in_if.op == OP_SAMPLE);
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_neg_r  <= s0_neg;
      s1_tail_r <= s0_tail;
      s1_be_r   <= in_if.block_end;
      s1_frac_r <= s0_scaled[FRAC_W-1:0];
      s1_dm_r   <= DM_W'(s0_mag - MAG_W'(ONE_Q16));
    end
  end

  // stage 2: difference and multiplier operand select
  logic signed [OP_W-1:0]    s2_diff;
  logic signed [SLOPE_W-1:0] s2_slope;
  logic signed [OP_W-1:0]    mul_a_nxt;
  logic signed [MB_W-1:0]    mul_b_nxt;
  logic signed [OP_W-1:0]    base_nxt;

  always_comb begin
    s2_diff = OP_W'($signed(e1_q)) - OP_W'($signed(e0_q));
    if (tail_slope_r > SLOPE_HI) begin
      s2_slope = SLOPE_HI;
    end else if (tail_slope_r < SLOPE_LO) begin
      s2_slope = SLOPE_LO;
    end else begin
      s2_slope = tail_slope_r;
    end
    if (s1_tail_r) begin
      mul_a_nxt = s2_slope;
      mul_b_nxt = $signed({1'b0, s1_dm_r});
      base_nxt  = OP_W'(tail_offset_r);
    end else begin
      mul_a_nxt = s2_diff;
      mul_b_nxt = $signed(MB_W'(s1_frac_r));
      base_nxt  = OP_W'($signed(e0_q));
    end
  end

  logic                   s2_valid_r;
  logic                   s2_neg_r;
  logic                   s2_tail_r;
  logic                   s2_be_r;
  logic signed [OP_W-1:0] mul_a_r;
  logic signed [MB_W-1:0] mul_b_r;
  logic signed [OP_W-1:0] s2_base_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
    end else if (adv) begin
      s2_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s2_neg_r  <= s1_neg_r;
      s2_tail_r <= s1_tail_r;
      s2_be_r   <= s1_be_r;
      mul_a_r   <= mul_a_nxt;
      mul_b_r   <= mul_b_nxt;
      s2_base_r <= base_nxt;
    end
  end

  // stage 3: shared multiplier for interpolation and tail
  logic                     s3_valid_r;
  logic                     s3_neg_r;
  logic                     s3_tail_r;
  logic                     s3_be_r;
  logic signed [PROD_W-1:0] prod_r;
  logic signed [OP_W-1:0]   s3_base_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_valid_r <= 1'b0;
    end else if (adv) begin
      s3_valid_r <= s2_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s3_neg_r  <= s2_neg_r;
      s3_tail_r <= s2_tail_r;
      s3_be_r   <= s2_be_r;
      prod_r    <= mul_a_r * mul_b_r;
      s3_base_r <= s2_base_r;
    end
  end

  // stage 4: floor shift, add base, saturate
  logic signed [PROD_W-1:0]       s4_shifted;
  logic signed [SUM_W-1:0]        s4_sum;
  logic signed [SAMPLE_OUT_W-1:0] y_nxt;

  always_comb begin
    s4_shifted = s3_tail_r ? (prod_r >>> Q_FRAC) : (prod_r >>> FRAC_W);
    s4_sum     = SUM_W'(s4_shifted) + SUM_W'(s3_base_r);
    if (s4_sum > SUM_MAX) begin
      y_nxt = Y_MAX;
    end else if (s4_sum < SUM_MIN) begin
      y_nxt = Y_MIN;
    end else begin
      y_nxt = SAMPLE_OUT_W'(s4_sum);
    end
  end

  logic                           s4_valid_r;
  logic                           s4_neg_r;
  logic                           s4_be_r;
  logic signed [SAMPLE_OUT_W-1:0] y_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s4_valid_r <= 1'b0;
    end else if (adv) begin
      s4_valid_r <= s3_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s4_neg_r <= s3_neg_r;
      s4_be_r  <= s3_be_r;
      y_r      <= y_nxt;
    end
  end

  // stage 5: apply sign with saturated negation, output register
  logic signed [SAMPLE_OUT_W-1:0] out_sample_nxt;

  always_comb begin
    if (!s4_neg_r) begin
      out_sample_nxt = y_r;
    end else if (y_r == Y_MIN) begin
      out_sample_nxt = Y_MAX;
    end else begin
      out_sample_nxt = -y_r;
    end
  end

  logic signed [SAMPLE_OUT_W-1:0] out_sample_r;
  logic                           out_be_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= s4_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_sample_r <= out_sample_nxt;
      out_be_r     <= s4_be_r;
    end
  end

  assign out_if.valid         = out_valid_r;
  assign out_if.sample_out    = out_sample_r;
  assign out_if.block_end_out = out_be_r;

endmodule

// ===== hw/rtl/ostw_ram.sv =====
// ----------------------------------------------------------------------------
// ostw_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module ostw_ram #(
  parameter int WIDTH = 18,
  parameter int DEPTH = 513
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port, holds while re is low
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
